### hdl/rkm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Response keyword matcher package
// Shared types and codes for the keyword matcher and its checker.
// ----------------------------------------------------------------------------
package rkm_pkg;

   // Request mode codes. The fourth code carries no meaning and is ignored.
   typedef enum logic [1:0] {
      MODE_ARM  = 2'd0,
      MODE_BYTE = 2'd1,
      MODE_TICK = 2'd2
   } mode_type;

   // Response outcome codes.
   typedef enum logic {
      OUTCOME_MATCH   = 1'b0,
      OUTCOME_TIMEOUT = 1'b1
   } outcome_type;

   typedef logic [2:0]  csr_index_type;
   typedef logic [63:0] csr_data_type;

   // Register map. Keyword k characters 0 to 7 sit at index 2k, 8 to 15 at 2k+1.
   localparam csr_index_type CSR_KW_CHARS_BASE   = 3'd0;
   localparam csr_index_type CSR_KEYWORD_LENGTHS = 3'd6;
   localparam csr_index_type CSR_TIMEOUT_TICKS   = 3'd7;

   localparam int LEN_FIELD_W    = 5;
   localparam int CHARS_PER_WORD = 8;
   localparam int TICK_W         = 16;

   typedef logic [7:0]        char_type;
   typedef logic [TICK_W-1:0] tick_type;
   typedef logic [1:0]        keyword_index_type;

endpackage

### hdl/response_keyword_matcher_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Response keyword matcher unit
// Searches a received byte stream for the first of several configured
// keywords and reports either the matching keyword or a tick timeout.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake              Payload
//   req_      in         req_valid / req_stall  req_mode, req_rx_byte
//   rsp_      out        rsp_valid / rsp_stall  rsp_outcome, rsp_keyword_index
//   csr_      in         csr_write_en           csr_index, csr_wdata
//
// For every request, the match counters, tick counter and armed flag update
// at the edge that accepts it, and a response, if any, appears in the
// response register on the next cycle. A new request is accepted in
// every cycle, limited only by the single response register.
// Reset is synchronous and active high; it clears all configuration, counts
// and the armed flag, so the block starts idle.
// req_stall rises only while a response is held and rsp_stall is high.
//
module response_keyword_matcher_unit #(
   parameter int KEYWORDS        = 3,
   parameter int KEYWORD_LEN_MAX = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   // Request channel.
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_mode,
   input  logic [7:0]                    req_rx_byte,
   // Response channel.
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_outcome,
   output logic [1:0]                    rsp_keyword_index,
   // Configuration write port.
   input  logic                          csr_write_en,
   input  rkm_pkg::csr_index_type        csr_index,
   input  rkm_pkg::csr_data_type         csr_wdata
);

   // A match count never exceeds the clamped keyword length.
   localparam int CNT_W = $clog2(KEYWORD_LEN_MAX + 1);

   typedef logic [CNT_W-1:0] count_type;

   // Configuration storage. Only characters that a keyword of the largest
   // length can reach are kept.
   rkm_pkg::char_type  kw_chars_ff [KEYWORDS][KEYWORD_LEN_MAX];
   count_type          kw_len_ff   [KEYWORDS];
   rkm_pkg::tick_type  timeout_ff;

   // Search state.
   count_type          match_count_ff [KEYWORDS];
   count_type          match_count_in [KEYWORDS];
   rkm_pkg::tick_type  elapsed_ff;
   rkm_pkg::tick_type  elapsed_in;
   logic               armed_ff;
   logic               armed_in;

   // Response register.
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic               rsp_outcome_ff;
   logic               rsp_outcome_in;
   logic [1:0]         rsp_index_ff;
   logic [1:0]         rsp_index_in;

   logic               req_accept;
   logic               result_hit;
   logic               result_outcome;
   logic [1:0]         result_index;
   rkm_pkg::mode_type  mode;
   rkm_pkg::tick_type  tick_next;

   // The response register empties when it is taken, so a request can enter
   // in the same cycle that the previous response leaves.
   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;
   assign mode       = rkm_pkg::mode_type'(req_mode);

   // ------------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------------
   for (genvar k = 0; k < KEYWORDS; k++) begin : g_kw_cfg
      for (genvar p = 0; p < KEYWORD_LEN_MAX; p++) begin : g_char
         localparam rkm_pkg::csr_index_type CharReg = rkm_pkg::csr_index_type'(
            int'(rkm_pkg::CSR_KW_CHARS_BASE) + 2 * k + p / rkm_pkg::CHARS_PER_WORD);
         localparam int CharLsb = 8 * (p % rkm_pkg::CHARS_PER_WORD);

         always_ff @(posedge clock) begin
            if (reset) begin
               kw_chars_ff[k][p] <= '0;
            end else if (csr_write_en && csr_index == CharReg) begin
               kw_chars_ff[k][p] <= csr_wdata[CharLsb +: 8];
            end
         end
      end

      // Lengths above the largest supported one are clamped when written.
      logic [rkm_pkg::LEN_FIELD_W-1:0] len_raw;
      count_type                       len_clamped;

      assign len_raw = csr_wdata[rkm_pkg::LEN_FIELD_W * k +: rkm_pkg::LEN_FIELD_W];

      always_comb begin
         if (len_raw > rkm_pkg::LEN_FIELD_W'(KEYWORD_LEN_MAX)) begin
            len_clamped = CNT_W'(KEYWORD_LEN_MAX);
         end else begin
            len_clamped = CNT_W'(len_raw);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            kw_len_ff[k] <= '0;
         end else if (csr_write_en && csr_index == rkm_pkg::CSR_KEYWORD_LENGTHS) begin
            kw_len_ff[k] <= len_clamped;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= '0;
      end else if (csr_write_en && csr_index == rkm_pkg::CSR_TIMEOUT_TICKS) begin
         timeout_ff <= csr_wdata[rkm_pkg::TICK_W-1:0];
      end
   end

   // ------------------------------------------------------------------------
   // Per-keyword compare: does the byte equal the next expected character?
   // Each position is compared in parallel and the one at the count selected.
   // ------------------------------------------------------------------------
   logic char_hit [KEYWORDS];

   for (genvar k = 0; k < KEYWORDS; k++) begin : g_cmp
      logic [KEYWORD_LEN_MAX-1:0] pos_hit;

      for (genvar p = 0; p < KEYWORD_LEN_MAX; p++) begin : g_pos
         assign pos_hit[p] = (match_count_ff[k] == CNT_W'(p))
                             && (req_rx_byte == kw_chars_ff[k][p]);
      end

      assign char_hit[k] = (match_count_ff[k] < kw_len_ff[k]) && (|pos_hit);
   end

   // ------------------------------------------------------------------------
   // Next state and result. Keywords are scanned in index order; once one
   // completes, the counts of the keywords after it are left as they are.
   // ------------------------------------------------------------------------
   assign tick_next = (elapsed_ff == '1) ? elapsed_ff : elapsed_ff + 1'b1;

   always_comb begin
      match_count_in = match_count_ff;
      elapsed_in     = elapsed_ff;
      armed_in       = armed_ff;
      result_hit     = 1'b0;
      result_outcome = rkm_pkg::OUTCOME_MATCH;
      result_index   = '0;

      if (req_accept) begin
         case (mode)
            rkm_pkg::MODE_ARM: begin
               for (int k = 0; k < KEYWORDS; k++) begin
                  match_count_in[k] = '0;
               end
               elapsed_in = '0;
               armed_in   = 1'b1;
               // A zero timeout expires on the arm request itself.
               if (timeout_ff == '0) begin
                  armed_in       = 1'b0;
                  result_hit     = 1'b1;
                  result_outcome = rkm_pkg::OUTCOME_TIMEOUT;
               end
            end
            rkm_pkg::MODE_BYTE: begin
               if (armed_ff) begin
                  for (int k = 0; k < KEYWORDS; k++) begin
                     if (!result_hit) begin
                        if (kw_len_ff[k] == '0) begin
                           match_count_in[k] = '0;
                        end else if (char_hit[k]) begin
                           match_count_in[k] = match_count_ff[k] + 1'b1;
                        end else begin
                           match_count_in[k] = '0;
                        end
                        if (kw_len_ff[k] != '0 && match_count_in[k] == kw_len_ff[k]) begin
                           result_hit     = 1'b1;
                           result_outcome = rkm_pkg::OUTCOME_MATCH;
                           result_index   = 2'(k);
                           armed_in       = 1'b0;
                        end
                     end
                  end
               end
            end
            rkm_pkg::MODE_TICK: begin
               if (armed_ff) begin
                  elapsed_in = tick_next;
                  if (tick_next >= timeout_ff) begin
                     armed_in       = 1'b0;
                     result_hit     = 1'b1;
                     result_outcome = rkm_pkg::OUTCOME_TIMEOUT;
                  end
               end
            end
            default: begin
               // The unused mode code leaves everything unchanged.
            end
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Response register: loaded on a result, emptied when taken.
   // ------------------------------------------------------------------------
   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_outcome_in = rsp_outcome_ff;
      rsp_index_in   = rsp_index_ff;
      if (result_hit) begin
         rsp_valid_in   = 1'b1;
         rsp_outcome_in = result_outcome;
         rsp_index_in   = result_index;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < KEYWORDS; k++) begin
            match_count_ff[k] <= '0;
         end
         elapsed_ff   <= '0;
         armed_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         match_count_ff <= match_count_in;
         elapsed_ff     <= elapsed_in;
         armed_ff       <= armed_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_outcome_ff <= rsp_outcome_in;
      rsp_index_ff   <= rsp_index_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_outcome       = rsp_outcome_ff;
   assign rsp_keyword_index = rsp_index_ff;

endmodule

### hdl/rkm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Response keyword matcher checker
// Port-level checks on the matcher's request and response channels.
// ----------------------------------------------------------------------------
module rkm_checker #(
   parameter int KEYWORDS = 3
) (
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_outcome,
   input logic [1:0] rsp_keyword_index
);

   // No response is pending right after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A held response keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_outcome)
                                 && $stable(rsp_keyword_index))
      else $error("stalled response changed");

   // Requests are only held back while a response is blocked.
   a_req_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without blocked response");

   // A timeout reports index zero and a match names a configured keyword.
   a_index_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_outcome == rkm_pkg::OUTCOME_TIMEOUT && rsp_keyword_index == 2'd0)
                    || (rsp_outcome == rkm_pkg::OUTCOME_MATCH
                        && int'(rsp_keyword_index) < KEYWORDS))
      else $error("response keyword index out of range");

endmodule

bind response_keyword_matcher_unit rkm_checker #(
   .KEYWORDS (KEYWORDS)
) u_rkm_checker (
   .clock             (clock),
   .reset             (reset),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_outcome       (rsp_outcome),
   .rsp_keyword_index (rsp_keyword_index)
);
